[rtl/ptms_pkg.sv]
// ----------------------------------------------------------------------------
// ptms_pkg: shared types and constants for the prime table membership search
// Holds the table size default, the controller states and the command and
// status structs passed between controller and datapath.
// ----------------------------------------------------------------------------
package ptms_pkg;

  localparam int unsigned TableSizeDefault = 2048;
  localparam int unsigned ValueW = 16;
  localparam int unsigned FirstPrime = 2;

  typedef enum logic [2:0] {
    ST_BUILD_TEST,
    ST_BUILD_DIV,
    ST_IDLE,
    ST_PROBE,
    ST_WAIT_RD,
    ST_FINAL_RD
  } ctrl_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic cand_start;   // load divisor 2 and begin trial division
    logic div_step;     // run one trial division step
    logic cand_store;   // write candidate to table, bump fill count
    logic cand_next;    // advance the candidate
    logic query_load;   // capture query, set search window
    logic probe_issue;  // read table at the midpoint
    logic probe_update; // narrow window from read data
    logic final_issue;  // read table at lo
    logic result_load;  // register the answer
  } dp_cmd_t;

  // Status from the datapath back to the controller
  typedef struct packed {
    logic div_busy;     // trial division still running
    logic cand_prime;   // candidate found prime
    logic table_full;   // next store fills the last entry
    logic window_done;  // lo equals hi
    logic sq_over;      // trial divisor squared exceeds the candidate
  } dp_status_t;

endpackage

[rtl/ptms_divider.sv]
// ----------------------------------------------------------------------------
// ptms_divider: iterative remainder unit
// Computes dividend mod divisor by restoring division, one quotient bit a
// cycle, for the trial division of table candidates.
// ----------------------------------------------------------------------------
module ptms_divider
  import ptms_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ValueW-1:0] dividend_i,
  input  logic [ValueW-1:0] divisor_i,
  output logic              busy_o,
  output logic              zero_rem_o
);

  localparam int unsigned CntW = $clog2(ValueW + 1);

  logic [ValueW-1:0] rem_q, rem_d;
  logic [ValueW-1:0] quo_q, quo_d;
  logic [ValueW-1:0] dsr_q, dsr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [ValueW:0]   trial;

  // Shift in one dividend bit and subtract when it fits
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    dsr_d = dsr_q;
    cnt_d = cnt_q;
    trial = {rem_q, quo_q[ValueW-1]} - {1'b0, dsr_q};
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      dsr_d = divisor_i;
      cnt_d = CntW'(ValueW);
    end else if (cnt_q != '0) begin
      quo_d = {quo_q[ValueW-2:0], 1'b0};
      if (!trial[ValueW]) begin
        rem_d = trial[ValueW-1:0];
      end else begin
        rem_d = {rem_q[ValueW-2:0], quo_q[ValueW-1]};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign busy_o     = (cnt_q != '0);
  assign zero_rem_o = (rem_q == '0);

endmodule

[rtl/ptms_datapath.sv]
// ----------------------------------------------------------------------------
// ptms_datapath: table memory, prime builder and search window
// Holds the prime memory, the candidate and divisor registers, the binary
// search bounds and the result register.
// ----------------------------------------------------------------------------
module ptms_datapath
  import ptms_pkg::*;
#(
  parameter int unsigned TableSize = TableSizeDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_status_t        status_o,
  input  logic [ValueW-1:0] query_value_i,
  output logic              is_prime_o,
  output logic              above_table_o
);

  localparam int unsigned IdxW = $clog2(TableSize);
  localparam int unsigned FillW = IdxW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableSize - 1);

  logic [ValueW-1:0] mem_q [TableSize];
  logic [ValueW-1:0] rd_q;
  logic [ValueW-1:0] top_q;

  logic [FillW-1:0]  fill_q;
  logic [ValueW-1:0] cand_q;
  logic [ValueW-1:0] div_q;
  logic              div_fail_q;
  logic              div_started_q;
  logic [ValueW-1:0] query_q;
  logic [IdxW-1:0]   lo_q, hi_q, mid;
  logic              is_prime_q, above_q;

  logic              dv_busy, dv_zero;
  logic [2*ValueW-1:0] div_sq;
  logic              sq_over;

  // Midpoint of the search window
  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  // Square the trial divisor to stop once it passes the square root
  assign div_sq  = div_q * div_q;
  assign sq_over = (div_sq > {{ValueW{1'b0}}, cand_q});

  ptms_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_step),
    .dividend_i (cand_q),
    .divisor_i  (div_q),
    .busy_o     (dv_busy),
    .zero_rem_o (dv_zero)
  );

  // Trial division bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q        <= '0;
      cand_q        <= ValueW'(FirstPrime);
      div_fail_q    <= 1'b0;
      div_started_q <= 1'b0;
      div_q         <= ValueW'(FirstPrime);
    end else begin
      if (cmd_i.cand_start) begin
        div_q         <= ValueW'(FirstPrime);
        div_fail_q    <= 1'b0;
        div_started_q <= 1'b0;
      end else if (cmd_i.div_step) begin
        div_started_q <= 1'b1;
      end else if (div_started_q && !dv_busy) begin
        div_started_q <= 1'b0;
        if (dv_zero) begin
          div_fail_q <= 1'b1;
        end
        div_q <= div_q + 1'b1;
      end
      if (cmd_i.cand_store) begin
        fill_q <= fill_q + 1'b1;
      end
      if (cmd_i.cand_next) begin
        cand_q <= cand_q + 1'b1;
      end
    end
  end

  // Store primes and read probes on one memory port pair
  always_ff @(posedge clk_i) begin
    if (cmd_i.cand_store) begin
      mem_q[fill_q[IdxW-1:0]] <= cand_q;
    end
    if (cmd_i.probe_issue) begin
      rd_q <= mem_q[mid];
    end else if (cmd_i.final_issue) begin
      rd_q <= mem_q[lo_q];
    end
    if (cmd_i.cand_store && (fill_q[IdxW-1:0] == LastIdx)) begin
      top_q <= cand_q;
    end
  end

  // Search window and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.query_load) begin
      query_q <= query_value_i;
      lo_q    <= '0;
      hi_q    <= LastIdx;
    end else if (cmd_i.probe_update) begin
      if (rd_q < query_q) begin
        lo_q <= mid + 1'b1;
      end else begin
        hi_q <= mid;
      end
    end
    if (cmd_i.result_load) begin
      is_prime_q <= (rd_q == query_q);
      above_q    <= (query_q > top_q);
    end
  end

  // Report status and drive the result ports
  assign status_o.div_busy    = div_started_q || dv_busy;
  assign status_o.cand_prime  = !div_fail_q;
  assign status_o.table_full  = (fill_q[IdxW-1:0] == LastIdx);
  assign status_o.window_done = (lo_q == hi_q);
  assign status_o.sq_over     = sq_over;
  assign is_prime_o           = is_prime_q;
  assign above_table_o        = above_q;

endmodule

[rtl/ptms_ctrl.sv]
// ----------------------------------------------------------------------------
// ptms_ctrl: sequencer for table build and query search
// Steps trial division per candidate after reset, then runs one binary
// search per accepted beat and holds the result until it is taken.
// ----------------------------------------------------------------------------
module ptms_ctrl
  import ptms_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_BUILD_TEST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q;
    // Drop the result beat once it is taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_BUILD_TEST: begin
        if (status_i.div_busy) begin
          state_d = ST_BUILD_TEST;
        end else if (!status_i.cand_prime) begin
          cmd_o.cand_next  = 1'b1;
          cmd_o.cand_start = 1'b1;
        end else if (status_i.sq_over) begin
          cmd_o.cand_store = 1'b1;
          cmd_o.cand_next  = 1'b1;
          cmd_o.cand_start = 1'b1;
          if (status_i.table_full) begin
            state_d = ST_IDLE;
          end
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_BUILD_DIV: begin
        state_d = ST_BUILD_TEST;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.query_load = 1'b1;
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (status_i.window_done) begin
          cmd_o.final_issue = 1'b1;
          state_d = ST_FINAL_RD;
        end else begin
          cmd_o.probe_issue = 1'b1;
          state_d = ST_WAIT_RD;
        end
      end
      ST_WAIT_RD: begin
        cmd_o.probe_update = 1'b1;
        state_d = ST_PROBE;
      end
      ST_FINAL_RD: begin
        // Hold the answer in rd_q while the previous beat still waits
        if (!out_valid_q || out_ready_i) begin
          cmd_o.result_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_BUILD_TEST;
      end
    endcase
  end

endmodule

[rtl/prime_table_membership_search.sv]
// Each probe takes one table read and one window update; a final read at lo
// then loads the result, which waits while the previous result beat is held.
// Queries do not overlap: a new query is taken only after the previous search
// ends, and it is taken while the previous result beat still waits.
// Reset: after rst_ni the table is built by trial division with a 16-step
// remainder unit; no query is accepted until all TABLE_SIZE primes are stored.
// ----------------------------------------------------------------------------
// prime_table_membership_search: top level
// Joins the build and search sequencer to the table datapath.
// ----------------------------------------------------------------------------
module prime_table_membership_search
  import ptms_pkg::*;
#(
  parameter int unsigned TableSize = TableSizeDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ValueW-1:0] query_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              is_prime_o,
  output logic              above_table_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  ptms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ptms_datapath #(
    .TableSize (TableSize)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .query_value_i (query_value_i),
    .is_prime_o    (is_prime_o),
    .above_table_o (above_table_o)
  );

endmodule

[rtl/ptms_checker.sv]
// ----------------------------------------------------------------------------
// ptms_checker: port-level checks for the prime table search
// Watches the handshakes and result flags at the top level ports.
// ----------------------------------------------------------------------------
module ptms_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic is_prime_o,
  input logic above_table_o
);

  // A prime answer never also claims the query is beyond the table
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_prime_o && above_table_o)) else $error("flags clash");

  // Held result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(is_prime_o)
    && $stable(above_table_o)) else $error("result dropped");

  // A fresh query beat never raises a result the next cycle
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o)) else $error("early result");

endmodule

bind prime_table_membership_search ptms_checker u_chk (.*);
